// ===== sv/brg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bounded random generator.
// Used by brg_ctrl, brg_datapath and bounded_random_generator_core; no dependencies.
package brg_pkg;

  localparam int unsigned WordWidth   = 32;
  localparam int unsigned ValueWidth  = 64;
  localparam int unsigned ActionWidth = 2;
  localparam int unsigned MaxTries    = 64;
  localparam int unsigned TryWidth    = $clog2(MaxTries);

  localparam logic [WordWidth-1:0] GoldenStep = 32'h9E37_79B9;
  localparam logic [WordWidth-1:0] MixMulA    = 32'h21F0_AAAD;
  localparam logic [WordWidth-1:0] MixMulB    = 32'h735A_2D97;
  localparam logic [WordWidth-1:0] SeedReset  = 32'd1;

  // Request codes carried in the action field
  localparam logic [ActionWidth-1:0] ActWord32 = 2'd0;
  localparam logic [ActionWidth-1:0] ActWord64 = 2'd1;
  localparam logic [ActionWidth-1:0] ActRange  = 2'd2;

  typedef enum logic [2:0] {
    RES_ZERO   = 3'd0,
    RES_WORD32 = 3'd1,
    RES_WORD64 = 3'd2,
    RES_RANGE  = 3'd3,
    RES_ERROR  = 3'd4
  } result_sel_t;

  typedef struct packed {
    logic [ActionWidth-1:0] action;
    logic [ValueWidth-1:0]  range_low;
    logic [ValueWidth-1:0]  range_high;
  } in_item_t;

  typedef struct packed {
    logic [ValueWidth-1:0] random_value;
    logic                  range_error;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic        capture;
    logic        setup;
    logic        make_mask;
    logic        mix_a;
    logic        mix_b;
    logic        mix_c;
    logic        to_high;
    logic        check;
    logic        finish;
    result_sel_t sel;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ActionWidth-1:0] action;
    logic                   inverted;
    logic                   full;
    logic                   fits;
    logic                   out_free;
  } dp_status_t;

endpackage

// ===== sv/bounded_random_generator_core.sv =====
`timescale 1ns / 1ps
// Top level of the bounded random generator: controller plus datapath.
// Depends on brg_pkg, brg_ctrl and brg_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) takes one request item:
//   a 32-bit word, a 64-bit word (high half drawn first) or an unbiased value
//   in [range_low, range_high]. Output channel (out_valid / out_stall /
//   out_item) returns exactly one item per request.
//   Each draw of the 32-bit mixer takes two multiplies, each registered, then the
//   final xor-shift. The multiplier sets the pace.
//   A bounded value takes at most 64 attempts, under two on average; if all are
//   rejected, the last masked draw is folded back under the span. A new item is
//   accepted the cycle after the previous result is loaded.
//   A finished result sits in the output register; if the receiver stalls,
//   the block still accepts and works on the next item and holds it in the
//   last state until the output register frees up.
//   Reset clears the state word to zero (first draw loads the seed) and sets
//   the seed register to 1. cfg_write loads the seed; write it only when idle.
module bounded_random_generator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  brg_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output brg_pkg::out_item_t out_item
);
  import brg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequence the item: decode, range setup, draws, rejection retries
  brg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold the seed and state word, mix, test the draw and register the result
  brg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== sv/brg_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: seed and state registers, the two-multiply mixer, range setup, mask,
// rejection test and the output register. Depends on brg_pkg.
module brg_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [31:0]         cfg_data,
  input  brg_pkg::in_item_t   in_item,
  input  brg_pkg::dp_cmd_t    cmd,
  output brg_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_stall,
  output brg_pkg::out_item_t  out_item
);
  import brg_pkg::*;

  logic [ActionWidth-1:0] action;
  logic [ValueWidth-1:0]  range_low;
  logic [ValueWidth-1:0]  range_high;
  logic [WordWidth-1:0]   seed;
  logic [WordWidth-1:0]   gen_word;
  logic [WordWidth-1:0]   prod;
  logic [WordWidth-1:0]   word_hi;
  logic [WordWidth-1:0]   word_lo;
  logic [ValueWidth-1:0]  span;
  logic [ValueWidth-1:0]  mask;
  logic [ValueWidth-1:0]  offset;
  logic                   inverted;
  logic                   full;

  logic [WordWidth-1:0]   load_word;
  logic [WordWidth-1:0]   mix_in_a;
  logic [WordWidth-1:0]   mix_in_b;
  logic [WordWidth-1:0]   mix_out;
  logic [ValueWidth-1:0]  mask_next;
  logic [ValueWidth-1:0]  masked;
  logic [ValueWidth:0]    diff;
  out_item_t              result;

  // A zero state word takes the seed first
  assign load_word = (gen_word == '0) ? seed : gen_word;
  assign mix_in_a  = load_word ^ (load_word >> 16);
  assign mix_in_b  = prod ^ (prod >> 15);
  assign mix_out   = prod ^ (prod >> 15);

  always_comb begin
    mask_next = span;
    mask_next = mask_next | (mask_next >> 1);
    mask_next = mask_next | (mask_next >> 2);
    mask_next = mask_next | (mask_next >> 4);
    mask_next = mask_next | (mask_next >> 8);
    mask_next = mask_next | (mask_next >> 16);
    mask_next = mask_next | (mask_next >> 32);
  end

  // Borrow out of draw - span says the draw fits
  assign masked = {word_hi, word_lo} & mask;
  assign diff   = {1'b0, masked} - {1'b0, span};

  always_comb begin
    result = '0;
    case (cmd.sel)
      RES_ZERO:   result = '0;
      RES_WORD32: result.random_value = {{(ValueWidth-WordWidth){1'b0}}, word_lo};
      RES_WORD64: result.random_value = {word_hi, word_lo};
      RES_RANGE:  result.random_value = range_low + offset;
      RES_ERROR:  result.range_error = 1'b1;
      default:    result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= SeedReset;
      gen_word  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        seed <= cfg_data;
      end
      if (cmd.mix_a) begin
        gen_word <= load_word + GoldenStep;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action     <= in_item.action;
      range_low  <= in_item.range_low;
      range_high <= in_item.range_high;
    end
    if (cmd.setup) begin
      inverted <= range_low > range_high;
      full     <= (range_low == '0) && (&range_high);
      span     <= range_high - range_low + ValueWidth'(1);
    end
    if (cmd.make_mask) begin
      mask <= mask_next;
    end
    if (cmd.mix_a) begin
      prod <= mix_in_a * MixMulA;
    end else if (cmd.mix_b) begin
      prod <= mix_in_b * MixMulB;
    end
    if (cmd.mix_c) begin
      if (cmd.to_high) begin
        word_hi <= mix_out;
      end else begin
        word_lo <= mix_out;
      end
    end
    if (cmd.check) begin
      offset <= diff[ValueWidth] ? masked : diff[ValueWidth-1:0];
    end
    if (cmd.finish) begin
      out_item <= result;
    end
  end

  assign status.action   = action;
  assign status.inverted = inverted;
  assign status.full     = full;
  assign status.fits     = diff[ValueWidth];
  assign status.out_free = !out_valid || !out_stall;

endmodule

// ===== sv/brg_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences draws, range setup and rejection retries.
// Depends on brg_pkg.
module brg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  brg_pkg::dp_status_t status,
  output brg_pkg::dp_cmd_t    cmd
);
  import brg_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_DECODE = 9'b000000010,
    ST_SETUP  = 9'b000000100,
    ST_MASK   = 9'b000001000,
    ST_DRAW_A = 9'b000010000,
    ST_DRAW_B = 9'b000100000,
    ST_DRAW_C = 9'b001000000,
    ST_CHECK  = 9'b010000000,
    ST_DONE   = 9'b100000000
  } state_t;

  state_t             state, state_next;
  logic               high_half, high_half_next;
  logic               ranged, ranged_next;
  result_sel_t        sel, sel_next;
  logic [TryWidth-1:0] tries, tries_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    high_half_next = high_half;
    ranged_next    = ranged;
    sel_next       = sel;
    tries_next     = tries;
    cmd            = '0;
    cmd.sel        = sel;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        tries_next  = '0;
        ranged_next = 1'b0;
        case (status.action)
          ActWord32: begin
            high_half_next = 1'b0;
            sel_next       = RES_WORD32;
            state_next     = ST_DRAW_A;
          end
          ActWord64: begin
            high_half_next = 1'b1;
            sel_next       = RES_WORD64;
            state_next     = ST_DRAW_A;
          end
          ActRange: begin
            state_next = ST_SETUP;
          end
          default: begin
            sel_next   = RES_ZERO;
            state_next = ST_DONE;
          end
        endcase
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_MASK;
      end
      ST_MASK: begin
        cmd.make_mask = 1'b1;
        if (status.inverted) begin
          sel_next   = RES_ERROR;
          state_next = ST_DONE;
        end else begin
          // full range is a plain 64-bit word
          high_half_next = 1'b1;
          ranged_next    = !status.full;
          sel_next       = status.full ? RES_WORD64 : RES_RANGE;
          state_next     = ST_DRAW_A;
        end
      end
      ST_DRAW_A: begin
        cmd.mix_a  = 1'b1;
        state_next = ST_DRAW_B;
      end
      ST_DRAW_B: begin
        cmd.mix_b  = 1'b1;
        state_next = ST_DRAW_C;
      end
      ST_DRAW_C: begin
        cmd.mix_c   = 1'b1;
        cmd.to_high = high_half;
        if (high_half) begin
          high_half_next = 1'b0;
          state_next     = ST_DRAW_A;
        end else if (ranged) begin
          state_next = ST_CHECK;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        if (status.fits || (tries == TryWidth'(MaxTries - 1))) begin
          state_next = ST_DONE;
        end else begin
          tries_next     = tries + TryWidth'(1);
          high_half_next = 1'b1;
          state_next     = ST_DRAW_A;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      high_half <= 1'b0;
      ranged    <= 1'b0;
      sel       <= RES_ZERO;
      tries     <= '0;
    end else begin
      state     <= state_next;
      high_half <= high_half_next;
      ranged    <= ranged_next;
      sel       <= sel_next;
      tries     <= tries_next;
    end
  end

endmodule

// ===== dv/bounded_random_generator_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bounded_random_generator_core. It drives request items, predicts
// each result with a splitmix32 generator of its own and compares the results in order.
// Depends on brg_pkg and the RTL under sv/.
module bounded_random_generator_core_test;
  import brg_pkg::*;

  // Generator constants, kept here on purpose so that a wrong package value shows up
  localparam logic [31:0] GoldenRatioStep = 32'h9E37_79B9;
  localparam logic [31:0] MixMultA        = 32'h21F0_AAAD;
  localparam logic [31:0] MixMultB        = 32'h735A_2D97;
  // The negated step: a zero state loads it, and one draw brings the state back to zero.
  // Every draw then repeats the same word.
  localparam logic [31:0] ShortCycleSeed  = 32'h61C8_8647;
  localparam logic [1:0]  ActUnused       = 2'd3;
  localparam int unsigned TryLimit        = 64;

  localparam int unsigned ItemsPerPhase       = 366;
  localparam int unsigned MismatchReportLimit = 10;
  localparam int unsigned SettleCycles        = 40;
  // The slowest item makes 64 rejected attempts and then waits out a long
  // receiver stall. This limit covers every item at that cost several times over.
  localparam longint unsigned CycleLimit      = 4_000_000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;

  // Predictor state. Reset values: seed 1, generator word 0
  logic [31:0] model_seed = 32'd1;
  logic [31:0] model_word = '0;

  out_item_t       expected_results[$];
  out_item_t       oldest_expected;
  int unsigned     mismatch_count     = 0;
  int unsigned     sender_idle_pct    = 0;
  int unsigned     receiver_stall_pct = 0;
  longint unsigned cycle_count        = 0;

  bounded_random_generator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Generator prediction
  // ---------------------------------------------------------------------------

  // Mix one taken state value. Each multiply keeps the low 32 bits
  function automatic logic [31:0] splitmix_mix(input logic [31:0] x);
    logic [31:0] z;
    z = x ^ (x >> 16);
    z = z * MixMultA;
    z = z ^ (z >> 15);
    z = z * MixMultB;
    z = z ^ (z >> 15);
    return z;
  endfunction

  // One draw: load the seed into a zero state, take the word, advance by the step
  function automatic logic [31:0] draw_word();
    logic [31:0] taken;
    if (model_word == '0) model_word = model_seed;
    taken      = model_word;
    model_word = model_word + GoldenRatioStep;
    return splitmix_mix(taken);
  endfunction

  // 64-bit word from two draws. The high half is drawn first
  function automatic logic [63:0] draw_pair();
    logic [31:0] upper;
    logic [31:0] lower;
    upper = draw_word();
    lower = draw_word();
    return {upper, lower};
  endfunction

  // Bitmask rejection over [lo, hi]. Give up after the try limit and fold the last
  // masked draw back under the span.
  function automatic logic [63:0] draw_in_range(input logic [63:0] lo, input logic [63:0] hi);
    logic [63:0] span;
    logic [63:0] mask;
    logic [63:0] r;
    if (lo == '0 && hi == {64{1'b1}}) return draw_pair();
    span = hi - lo + 64'd1;
    mask = span;
    for (int s = 1; s < 64; s = s * 2) mask = mask | (mask >> s);
    r = '0;
    for (int t = 0; t < TryLimit; t++) begin
      r = draw_pair() & mask;
      if (r < span) return lo + r;
    end
    return lo + (r - span);
  endfunction

  function automatic out_item_t predict_result(input in_item_t req);
    out_item_t res;
    res = '0;
    case (req.action)
      ActWord32: res.random_value = {32'd0, draw_word()};
      ActWord64: res.random_value = draw_pair();
      ActRange: begin
        // An inverted range flags an error and leaves the state alone
        if (req.range_low > req.range_high) res.range_error = 1'b1;
        else res.random_value = draw_in_range(req.range_low, req.range_high);
      end
      default: ;  // unused code: zero result, no draw
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t make_request(input logic [1:0] act, input logic [63:0] lo,
                                            input logic [63:0] hi);
    in_item_t req;
    req.action     = act;
    req.range_low  = lo;
    req.range_high = hi;
    return req;
  endfunction

  // Words, unused codes and mostly well-formed ranges of random size and position. Spans
  // sit on a power of two, just past one or anywhere; rejection ranges from none to about half.
  function automatic in_item_t random_request();
    in_item_t    req;
    logic [63:0] span_m1;
    logic [63:0] swap;
    int unsigned pick;
    int unsigned width;
    req.range_low  = rand64();
    req.range_high = rand64();
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      req.action = ActWord32;
    end else if (pick < 44) begin
      req.action = ActWord64;
    end else if (pick < 95) begin
      req.action = ActRange;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        req.range_low  = '0;
        req.range_high = {64{1'b1}};
      end else if (pick < 14) begin
        // Force low above high
        if (req.range_low == req.range_high) begin
          req.range_low  = req.range_low | 64'd1;
          req.range_high = req.range_low - 64'd1;
        end else if (req.range_low < req.range_high) begin
          swap           = req.range_low;
          req.range_low  = req.range_high;
          req.range_high = swap;
        end
      end else begin
        width = $urandom_range(1, 64);
        case ($urandom_range(0, 2))
          0: span_m1 = {64{1'b1}} >> (64 - width);
          1: span_m1 = 64'd1 << (width - 1);
          default: span_m1 = rand64() >> (64 - width);
        endcase
        // Keep the upper bound from wrapping
        if (req.range_low > ~span_m1) req.range_low = req.range_low & ~span_m1;
        req.range_high = req.range_low + span_m1;
      end
    end else begin
      req.action = ActUnused;
    end
    return req;
  endfunction

  // Present one item and hold it until it is taken, then queue its prediction.
  // Valid stays high after the handshake. The next call either reuses it or
  // drops it while the sender idles.
  task automatic send_request(input in_item_t req);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_result(req));
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Only call while idle. The seed is the only configuration register
  task automatic write_seed(input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    model_seed = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Seed with a one-draw cycle: every draw gives the same word. Build a range whose
  // span is the top bit of that repeated pair. Every attempt then lands at or above
  // the span, and the try limit and its fallback come into play.
  task automatic test_short_cycle_seed();
    logic [31:0] repeated;
    logic [63:0] pair;
    logic [63:0] span;
    int          top;
    write_seed(ShortCycleSeed);
    send_request(make_request(ActWord32, '0, '0));
    send_request(make_request(ActWord64, '0, '0));
    send_request(make_request(ActRange, 64'd0, 64'd2));
    repeated = splitmix_mix(ShortCycleSeed);
    pair     = {repeated, repeated};
    top      = 63;
    while (top > 0 && !pair[top]) top--;
    span = 64'd1 << top;
    send_request(make_request(ActRange, 64'd5, 64'd5 + span - 64'd1));
    wait_idle();
  endtask

  // The state is zero again after the short cycle. A zero seed gives the mix of
  // zero, and after that the state advances normally.
  task automatic test_zero_seed();
    write_seed(32'd0);
    send_request(make_request(ActWord32, {64{1'b1}}, {64{1'b1}}));
    send_request(make_request(ActWord64, '0, {64{1'b1}}));
    wait_idle();
  endtask

  task automatic test_range_corners();
    send_request(make_request(ActRange, 64'd0, {64{1'b1}}));           // full range
    send_request(make_request(ActRange, 64'd1, 64'd0));                // inverted by one
    send_request(make_request(ActRange, {64{1'b1}}, 64'd0));           // inverted, widest
    send_request(make_request(ActRange, 64'd0, 64'd0));                // span of one
    send_request(make_request(ActRange, {64{1'b1}}, {64{1'b1}}));
    send_request(make_request(ActRange, 64'd0, 64'd1));
    send_request(make_request(ActRange, 64'd0, 64'h8000_0000_0000_0000)); // mask all ones
    send_request(make_request(ActRange, 64'd1, {64{1'b1}}));           // span all ones
    send_request(make_request(ActRange, {64{1'b1}} - 64'd1, {64{1'b1}}));
    send_request(make_request(ActUnused, {64{1'b1}}, {64{1'b1}}));
    send_request(make_request(ActUnused, 64'd0, 64'd0));
    send_request(make_request(ActWord32, {64{1'b1}}, 64'd0));
    send_request(make_request(ActWord64, 64'd0, {64{1'b1}}));
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input logic [31:0] seed);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    write_seed(seed);
    repeat (ItemsPerPhase) send_request(random_request());
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
  end

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MismatchReportLimit) $display("mismatch: %0s", msg);
  endtask

  // Compare each accepted result with the oldest prediction, field by field
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result value %h error %b",
                               out_item.random_value, out_item.range_error));
      end else begin
        oldest_expected = expected_results.pop_front();
        if (out_item.random_value !== oldest_expected.random_value)
          log_mismatch($sformatf("random_value expected %h, got %h",
                                 oldest_expected.random_value, out_item.random_value));
        if (out_item.range_error !== oldest_expected.range_error)
          log_mismatch($sformatf("range_error expected %b, got %b",
                                 oldest_expected.range_error, out_item.range_error));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("bounded_random_generator_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    sender_idle_pct    = 10;
    receiver_stall_pct = 25;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_short_cycle_seed();
    test_zero_seed();
    test_range_corners();
    // The state never returns to zero from here, so these seeds must not show
    test_random_traffic(30, 88, 32'hFFFF_FFFF);
    test_random_traffic(88, 30, $urandom());
    test_random_traffic(0, 0, 32'd1);

    // Let any stray result surface before the verdict
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("bounded_random_generator_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, expected_results.size());
      $display("bounded_random_generator_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== bounded_random_generator_core.f =====
sv/brg_pkg.sv
sv/brg_datapath.sv
sv/brg_ctrl.sv
sv/bounded_random_generator_core.sv
dv/bounded_random_generator_core_test.sv
